### rtl/pehr_pkg.sv
package pehr_pkg;

	// default sizes and reset values
	localparam int NUM_LINES_DEF    = 8;
	localparam int HOLDOFF_BITS_DEF = 16;
	localparam logic [15:0] HOLDOFF_RELOAD_RST = 16'd770;
	localparam logic [7:0]  ACTIVE_HIGH_RST    = 8'd11;

	// configuration port
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 16;
	localparam logic [CFG_INDEX_W-1:0] CFG_HOLDOFF_RELOAD   = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_HIGH_MASK = 4'd1;

	// input word kinds
	localparam logic [1:0] KIND_EDGE = 2'd0;
	localparam logic [1:0] KIND_TICK = 2'd1;
	localparam logic [1:0] KIND_DONE = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] line;
		logic [7:0] pin_levels;
	} in_word_t;

	typedef struct packed {
		logic [2:0] report_line;
		logic [7:0] pending_left;
	} out_word_t;

	// result from the decision stage toward the output register
	typedef struct packed {
		logic      valid;
		out_word_t word;
	} result_t;

	// input stage status toward the rest of the block
	typedef struct packed {
		logic     valid;
		in_word_t word;
	} stage_t;

endpackage

### rtl/pehr_in_reg.sv
module pehr_in_reg
	import pehr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  in_word_t in_word,
	input  logic     advance,
	output stage_t   stage
);

	logic     valid_s1;
	in_word_t word_s1;
	logic     accept;

	// hold off new words while the stage cannot drain
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= in_word;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.word  = word_s1;

endmodule

### rtl/pehr_engine.sv
module pehr_engine
	import pehr_pkg::*;
#(
	parameter int NUM_LINES    = NUM_LINES_DEF,
	parameter int HOLDOFF_BITS = HOLDOFF_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   advance,
	input  in_word_t               word,
	output result_t                result
);

	localparam int IDX_W = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;

	logic [15:0]             reload_q;
	logic [7:0]              act_high_q;
	logic [NUM_LINES-1:0]    pending_q;
	logic [HOLDOFF_BITS-1:0] holdoff_q;
	logic                    idle_q;

	logic [NUM_LINES-1:0]    pend_n;
	logic [NUM_LINES-1:0]    lowest;
	logic [NUM_LINES-1:0]    levels;
	logic [NUM_LINES-1:0]    act_high;
	logic [HOLDOFF_BITS-1:0] hold_n;
	logic                    idle_n;
	logic                    fire;
	logic                    match;
	logic [IDX_W-1:0]        sel_idx;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q   <= HOLDOFF_RELOAD_RST;
			act_high_q <= ACTIVE_HIGH_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HOLDOFF_RELOAD:   reload_q   <= cfg_data;
				CFG_ACTIVE_HIGH_MASK: act_high_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// state update for the word in the stage
	always_comb begin
		pend_n = pending_q;
		hold_n = holdoff_q;
		idle_n = idle_q;
		case (word.kind)
			KIND_EDGE: begin
				if (32'(word.line) < 32'(NUM_LINES)) begin
					pend_n = pending_q | (NUM_LINES'(1) << word.line);
					hold_n = HOLDOFF_BITS'(reload_q);
				end
			end
			KIND_TICK: begin
				if (holdoff_q != '0) begin
					hold_n = holdoff_q - HOLDOFF_BITS'(1);
				end
			end
			KIND_DONE: idle_n = 1'b1;
			default: ;
		endcase
	end

	// pick the highest priority pending line and check its polarity
	assign levels   = NUM_LINES'(word.pin_levels);
	assign act_high = NUM_LINES'(act_high_q);
	assign fire     = (pend_n != '0) && (hold_n == '0) && idle_n;
	assign lowest   = pend_n & (~pend_n + NUM_LINES'(1));
	assign match    = |(lowest & ~(levels ^ act_high));

	always_comb begin
		sel_idx = '0;
		for (int i = 0; i < NUM_LINES; i++) begin
			if (lowest[i]) begin
				sel_idx = sel_idx | IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			holdoff_q <= '0;
			idle_q    <= 1'b1;
		end else if (advance) begin
			holdoff_q <= hold_n;
			if (fire) begin
				pending_q <= pend_n & ~lowest;
				idle_q    <= idle_n && !match;
			end else begin
				pending_q <= pend_n;
				idle_q    <= idle_n;
			end
		end
	end

	assign result.valid             = fire && match;
	assign result.word.report_line  = 3'(sel_idx);
	assign result.word.pending_left = 8'(pend_n & ~lowest);

endmodule

### rtl/pehr_out_reg.sv
module pehr_out_reg
	import pehr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      stage_valid,
	input  result_t   result,
	output logic      advance,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_word
);

	logic      valid_q;
	out_word_t word_q;

	// the stage moves on once the result register is free or draining
	assign advance = stage_valid && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= result.valid;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			word_q <= result.word;
		end
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

### rtl/pin_event_holdoff_reporter_core.sv
// channel | direction | handshake            | word
// in      | input     | in_valid / in_stall   | in_word_t  (kind, line, pin_levels)
// out     | output    | out_valid / out_stall | out_word_t (report_line, pending_left)
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one word is taken per cycle while in_stall is low; it is held in the input register
// and its result is then registered in the result register, from which it is taken
// the input register feeds one stage of decision logic into the result register
// arst_n clears pending bits and holdoff, marks the transmitter idle, loads defaults
// a stalled result holds; the input takes one more word, then stalls with it
// cfg_ready is always high; writes are registered whenever cfg_valid is high
module pin_event_holdoff_reporter_core
	import pehr_pkg::*;
#(
	parameter int NUM_LINES    = NUM_LINES_DEF,
	parameter int HOLDOFF_BITS = HOLDOFF_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  in_word_t               in_word,
	output logic                   out_valid,
	input  logic                   out_stall,
	output out_word_t              out_word,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	stage_t  stage;
	result_t result;
	logic    advance;

	assign cfg_ready = 1'b1;

	// input register
	pehr_in_reg u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.advance  (advance),
		.stage    (stage)
	);

	// event state and report decision
	pehr_engine #(
		.NUM_LINES    (NUM_LINES),
		.HOLDOFF_BITS (HOLDOFF_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (advance),
		.word      (stage.word),
		.result    (result)
	);

	// result register
	pehr_out_reg u_out (
		.clk         (clk),
		.arst_n      (arst_n),
		.stage_valid (stage.valid),
		.result      (result),
		.advance     (advance),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_word    (out_word)
	);

endmodule

### rtl/pehr_checker.sv
module pehr_checker
	import pehr_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input in_word_t               in_word,
	input logic                   out_valid,
	input logic                   out_stall,
	input out_word_t              out_word,
	input logic                   cfg_valid,
	input logic                   cfg_ready
);

	// a held result word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("result word changed while stalled");

	// a stalled input word stays offered and unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_word))
		else $error("input word changed while stalled");

	// the input only stalls behind a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with the result side free");

	// the reported line and every higher priority line are cleared
	a_priority: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.pending_left
			& ((8'd2 << out_word.report_line) - 8'd1)) == 8'd0)
		else $error("reported line is not the highest priority pending");

	// configuration writes are never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write held off");

endmodule

bind pin_event_holdoff_reporter_core pehr_checker u_pehr_checker (.*);

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import pehr_pkg::*;

	localparam logic [1:0]             KIND_SPARE      = 2'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = 4'd9;
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_SHOWN      = 10;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	in_word_t               in_word;
	logic                   out_valid;
	logic                   out_stall;
	out_word_t              out_word;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// shadow of the block state and its registers
	logic [7:0]  pend_bits;
	logic [15:0] holdoff_cnt;
	logic        tx_idle;
	logic [15:0] cfg_reload;
	logic [7:0]  cfg_active_high;

	out_word_t report_q[$];

	int  n_words;
	int  n_reports;
	int  n_bad;
	int  n_reg_writes;
	int  quiet_cycles;
	int  stall_left;
	int  hold_cycles;
	bit  src_gaps;
	bit  sink_gaps;

	pin_event_holdoff_reporter_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// next state of the reporter for one word; returns 1 when a report goes out
	function automatic bit predict_report(input in_word_t w, output out_word_t r);
		int  i;
		bit  found;
		bit  hit;
		found = 1'b0;
		hit   = 1'b0;
		r     = '0;
		case (w.kind)
			KIND_EDGE: begin
				pend_bits[w.line] = 1'b1;
				holdoff_cnt = cfg_reload;
			end
			KIND_TICK: begin
				if (holdoff_cnt != 16'd0)
					holdoff_cnt = holdoff_cnt - 16'd1;
			end
			KIND_DONE: tx_idle = 1'b1;
			default: ;
		endcase
		if (pend_bits == 8'd0 || holdoff_cnt != 16'd0 || !tx_idle)
			return 1'b0;
		// highest priority pending line is taken and cleared
		for (i = 0; i < 8; i++) begin
			if (!found && pend_bits[i]) begin
				found = 1'b1;
				pend_bits[i] = 1'b0;
				if (w.pin_levels[i] == cfg_active_high[i]) begin
					hit = 1'b1;
					tx_idle = 1'b0;
					r.report_line  = 3'(i);
					r.pending_left = pend_bits;
				end
			end
		end
		return hit;
	endfunction

	// drive one input word and wait until it is taken
	task automatic send_word(input logic [1:0] kind, input logic [2:0] line,
			input logic [7:0] levels);
		in_word_t  w;
		out_word_t r;
		int        gap;
		w.kind       = kind;
		w.line       = line;
		w.pin_levels = levels;
		if (src_gaps && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_word  <= w;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		n_words++;
		if (predict_report(w, r))
			report_q.push_back(r);
	endtask

	// stop sending and let every expected report come out
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (report_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only once the block has gone quiet
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		wait_drained();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		n_reg_writes++;
		if (idx == CFG_HOLDOFF_RELOAD)
			cfg_reload = data;
		else if (idx == CFG_ACTIVE_HIGH_MASK)
			cfg_active_high = data[7:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// edge bursts, enough ticks to run out a holdoff reload of up to 3, then done words; some noise
	task automatic send_event_bursts(input int n_target);
		int sent;
		int k;
		int cnt;
		int ticks;
		sent = 0;
		while (sent < n_target) begin
			if ($urandom_range(0, 4) == 0) begin
				send_word(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
					8'($urandom_range(0, 255)));
				sent++;
			end else begin
				cnt = $urandom_range(1, 3);
				for (k = 0; k < cnt; k++) begin
					send_word(KIND_EDGE, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
					sent++;
				end
				ticks = (cfg_reload > 16'd3 ? 3 : int'(cfg_reload)) + $urandom_range(0, 1);
				for (k = 0; k < ticks; k++) begin
					send_word(KIND_TICK, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
					sent++;
				end
				cnt = $urandom_range(1, 3);
				for (k = 0; k < cnt; k++) begin
					send_word(KIND_DONE, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
					sent++;
				end
			end
		end
	endtask

	// defaults after reset: long holdoff keeps the edge back
	task automatic test_reset_defaults();
		send_word(KIND_EDGE, 3'd0, 8'h01);
		send_word(KIND_TICK, 3'd0, 8'h01);
		send_word(KIND_DONE, 3'd0, 8'h01);
		send_word(KIND_SPARE, 3'd7, 8'hFF);
		wait_drained();
	endtask

	// priority order, polarity mismatch, busy transmitter, unused kind and register index
	task automatic test_priority_polarity();
		write_reg(CFG_HOLDOFF_RELOAD, 16'd0);
		write_reg(CFG_ACTIVE_HIGH_MASK, 16'hFFFF);
		send_word(KIND_EDGE, 3'd7, 8'h80);
		send_word(KIND_EDGE, 3'd0, 8'h00);
		send_word(KIND_EDGE, 3'd4, 8'h00);
		send_word(KIND_DONE, 3'd0, 8'h10);
		send_word(KIND_SPARE, 3'd0, 8'hFF);
		send_word(KIND_DONE, 3'd0, 8'h00);
		write_reg(CFG_ACTIVE_HIGH_MASK, 16'h0000);
		write_reg(CFG_SPARE_INDEX, 16'hFFFF);
		send_word(KIND_EDGE, 3'd2, 8'hFF);
		send_word(KIND_EDGE, 3'd1, 8'h00);
		send_word(KIND_DONE, 3'd5, 8'h00);
	endtask

	// holdoff countdown, tick at zero, done while idle, widest reload
	task automatic test_holdoff();
		write_reg(CFG_HOLDOFF_RELOAD, 16'd2);
		send_word(KIND_EDGE, 3'd6, 8'h00);
		send_word(KIND_EDGE, 3'd3, 8'h00);
		send_word(KIND_TICK, 3'd0, 8'h00);
		send_word(KIND_TICK, 3'd0, 8'h00);
		send_word(KIND_TICK, 3'd0, 8'h00);
		send_word(KIND_DONE, 3'd0, 8'h00);
		send_word(KIND_DONE, 3'd0, 8'h00);
		write_reg(CFG_HOLDOFF_RELOAD, 16'hFFFF);
		send_word(KIND_EDGE, 3'd5, 8'h00);
		send_word(KIND_TICK, 3'd0, 8'h00);
		write_reg(CFG_HOLDOFF_RELOAD, 16'd0);
		send_word(KIND_EDGE, 3'd0, 8'h00);
		send_word(KIND_DONE, 3'd0, 8'hFF);
		wait_drained();
	endtask

	// random event traffic under a few register settings, idling on both sides
	task automatic test_random_traffic();
		src_gaps  = 1'b1;
		sink_gaps = 1'b1;
		write_reg(CFG_HOLDOFF_RELOAD, 16'd0);
		write_reg(CFG_ACTIVE_HIGH_MASK, 16'($urandom));
		send_event_bursts(100);
		write_reg(CFG_HOLDOFF_RELOAD, 16'd1);
		write_reg(CFG_ACTIVE_HIGH_MASK, 16'h00FF);
		send_event_bursts(100);
		write_reg(CFG_HOLDOFF_RELOAD, 16'd3);
		write_reg(CFG_ACTIVE_HIGH_MASK, 16'h0000);
		send_event_bursts(50);
		// sender holds back until all reports are out
		wait_drained();
		send_event_bursts(50);
	endtask

	// long receiver stall while words keep coming, so the input backs up
	task automatic test_backpressure();
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		write_reg(CFG_HOLDOFF_RELOAD, 16'd0);
		write_reg(CFG_ACTIVE_HIGH_MASK, 16'($urandom));
		@(posedge clk);
		hold_cycles = 64;
		send_event_bursts(40);
	endtask

	// closing stretch with no idling at all
	task automatic test_full_rate();
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		write_reg(CFG_HOLDOFF_RELOAD, 16'($urandom_range(0, 2)));
		write_reg(CFG_ACTIVE_HIGH_MASK, 16'($urandom));
		send_event_bursts(100);
	endtask

	// receiver stall: long hold first, then random bursts
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 7);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// compare each report against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			n_reports++;
			if (report_q.size() == 0) begin
				n_bad++;
				if (n_bad <= MAX_SHOWN)
					$display("unexpected report: line %0d pending %h",
						out_word.report_line, out_word.pending_left);
			end else begin
				if (out_word.report_line !== report_q[0].report_line ||
						out_word.pending_left !== report_q[0].pending_left) begin
					n_bad++;
					if (n_bad <= MAX_SHOWN)
						$display("report mismatch: expected line %0d pending %h, got line %0d pending %h",
							report_q[0].report_line, report_q[0].pending_left,
							out_word.report_line, out_word.pending_left);
				end
				void'(report_q.pop_front());
			end
		end
	end

	// watchdog on cycles with no handshake of any kind
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: %0d reports still expected", report_q.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_word      = '0;
		out_stall    = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		n_words      = 0;
		n_reports    = 0;
		n_bad        = 0;
		n_reg_writes = 0;
		quiet_cycles = 0;
		stall_left   = 0;
		hold_cycles  = 0;
		src_gaps     = 1'b0;
		sink_gaps    = 1'b0;
		pend_bits       = 8'd0;
		holdoff_cnt     = 16'd0;
		tx_idle         = 1'b1;
		cfg_reload      = HOLDOFF_RELOAD_RST;
		cfg_active_high = ACTIVE_HIGH_RST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_priority_polarity();
		test_holdoff();
		test_random_traffic();
		test_backpressure();
		test_full_rate();
		wait_drained();

		$display("covered %0d input words, %0d reports, %0d register writes",
			n_words, n_reports, n_reg_writes);
		$display("includes priority, polarity, holdoff, busy transmitter and stall cases");
		if (n_bad == 0 && report_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
